>>> rtl/core/lcdi2c_pkg.sv
package lcdi2c_pkg;

  // Depth of the expander byte queue.
  localparam int QUEUE_DEPTH = 6;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // A command or data byte turns into this many expander bytes.
  localparam int CMD_BYTES = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CMD   = 2'd1,
    OP_DATA  = 2'd2,
    OP_LIGHT = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADDR   = 3'd0,
    CFG_RS     = 3'd1,
    CFG_RW     = 3'd2,
    CFG_EN     = 3'd3,
    CFG_LIGHT  = 3'd4,
    CFG_NIBBLE = 3'd5
  } cfg_idx_t;

  // Bit slots of one I2C write frame.
  localparam logic [4:0] SLOT_START      = 5'd0;
  localparam logic [4:0] SLOT_ACK_ADDR   = 5'd9;
  localparam logic [4:0] SLOT_DATA_FIRST = 5'd10;
  localparam logic [4:0] SLOT_ACK_DATA   = 5'd18;
  localparam logic [4:0] SLOT_STOP       = 5'd19;

  // Ticks within a slot.
  localparam logic [1:0] SUB_SETUP = 2'd0;
  localparam logic [1:0] SUB_HIGH  = 2'd1;
  localparam logic [1:0] SUB_LOW   = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] value;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic nack_seen;
    logic request_dropped;
  } out_item_t;

  typedef struct packed {
    logic [2:0] rs;
    logic [2:0] rw;
    logic [2:0] en;
    logic [2:0] light;
    logic [2:0] nibble;
  } pins_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] shift;
    logic [4:0] slot;
    logic [1:0] sub;
  } bus_state_t;

  typedef struct packed {
    bus_state_t nxt;
    logic       nack_set;
    logic       frame_end;
  } bus_step_t;

  typedef struct packed {
    logic [CMD_BYTES-1:0][7:0] bytes;
    logic [7:0]                shadow;
    logic [QCNT_W-1:0]         count;
  } req_t;

  // Positions above bit 7 are dropped.
  function automatic logic [7:0] put_bit(input logic [7:0] v, input logic [3:0] pos,
                                         input logic b);
    logic [7:0] r;
    r = v;
    if (pos <= 4'd7) begin
      r[pos[2:0]] = b;
    end
    return r;
  endfunction

  function automatic logic [7:0] put_nibble(input logic [7:0] v, input logic [2:0] base,
                                            input logic [3:0] nib);
    logic [7:0] r;
    r = v;
    for (int k = 3; k >= 0; k--) begin
      r = put_bit(r, {1'b0, base} + 4'(k), nib[k]);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/lcdi2c_bus_seq.sv
// One tick of the I2C frame sequencer: line levels, shift byte and slot position.
module lcdi2c_bus_seq
  import lcdi2c_pkg::*;
(
  input  bus_state_t cur,
  input  logic [7:0] dev_addr,
  input  logic [7:0] head_byte,
  input  logic       sda_in,
  output bus_step_t  step
);

  logic [7:0] src;

  assign src = (cur.slot == SLOT_DATA_FIRST) ? head_byte : cur.shift;

  always_comb begin
    step           = '0;
    step.nxt       = cur;
    step.nack_set  = 1'b0;
    step.frame_end = 1'b0;

    priority if (cur.slot == SLOT_START) begin
      if (cur.sub == SUB_SETUP) begin
        step.nxt.scl   = 1'b1;
        step.nxt.sda   = 1'b1;
        step.nxt.shift = dev_addr;
      end else if (cur.sub == SUB_HIGH) begin
        step.nxt.sda = 1'b0;
      end else begin
        step.nxt.scl = 1'b0;
      end
    end else if (cur.slot == SLOT_ACK_ADDR || cur.slot == SLOT_ACK_DATA) begin
      if (cur.sub == SUB_SETUP) begin
        step.nxt.sda = 1'b1;
      end else if (cur.sub == SUB_HIGH) begin
        step.nxt.scl  = 1'b1;
        step.nack_set = sda_in;
      end else begin
        step.nxt.scl = 1'b0;
      end
    end else if (cur.slot == SLOT_STOP) begin
      if (cur.sub == SUB_SETUP) begin
        step.nxt.sda = 1'b0;
      end else if (cur.sub == SUB_HIGH) begin
        step.nxt.scl = 1'b1;
      end else begin
        step.nxt.sda = 1'b1;
      end
    end else begin
      // Address and data bits, most significant first.
      if (cur.sub == SUB_SETUP) begin
        step.nxt.shift = src;
        step.nxt.sda   = src[7];
      end else if (cur.sub == SUB_HIGH) begin
        step.nxt.scl = 1'b1;
      end else begin
        step.nxt.scl   = 1'b0;
        step.nxt.shift = {cur.shift[6:0], 1'b0};
      end
    end

    if (cur.sub == SUB_LOW) begin
      step.nxt.sub = SUB_SETUP;
      if (cur.slot == SLOT_STOP) begin
        step.nxt.slot  = SLOT_START;
        step.frame_end = 1'b1;
      end else begin
        step.nxt.slot = cur.slot + 5'd1;
      end
    end else begin
      step.nxt.sub = cur.sub + 2'd1;
    end
  end

endmodule

>>> rtl/core/lcdi2c_req_build.sv
// Turns one request into the expander bytes it queues and the new pin shadow.
module lcdi2c_req_build
  import lcdi2c_pkg::*;
(
  input  logic [1:0] operation,
  input  logic [7:0] value,
  input  logic [7:0] shadow,
  input  pins_t      pins,
  output req_t       req
);

  logic [7:0] rs_b, rw_b, hi_n, hi_on, hi_off, lo_n, lo_on, lo_off, light_b;

  always_comb begin
    light_b = put_bit(shadow, {1'b0, pins.light}, value != 8'd0);
    // Later writes win where pin positions overlap.
    rs_b    = put_bit(shadow, {1'b0, pins.rs}, operation == OP_DATA);
    rw_b    = put_bit(rs_b, {1'b0, pins.rw}, 1'b0);
    hi_n    = put_nibble(rw_b, pins.nibble, value[7:4]);
    hi_on   = put_bit(hi_n, {1'b0, pins.en}, 1'b1);
    hi_off  = put_bit(hi_on, {1'b0, pins.en}, 1'b0);
    lo_n    = put_nibble(hi_off, pins.nibble, value[3:0]);
    lo_on   = put_bit(lo_n, {1'b0, pins.en}, 1'b1);
    lo_off  = put_bit(lo_on, {1'b0, pins.en}, 1'b0);

    if (operation == OP_LIGHT) begin
      req.bytes  = {CMD_BYTES{light_b}};
      req.shadow = light_b;
      req.count  = QCNT_W'(1);
    end else begin
      req.bytes  = {lo_off, lo_on, hi_off, hi_on, rw_b, rs_b};
      req.shadow = lo_off;
      req.count  = QCNT_W'(CMD_BYTES);
    end
  end

endmodule

>>> rtl/core/lcd_nibble_writer_over_i2c_expander.sv
// Character LCD writer over an 8-bit I2C port expander, bit-level I2C master.
//
// The input channel (in_valid, in_stall, in_data) carries one transaction per
// item: a tick, a command byte, a data byte or a backlight request. A command
// or data byte queues six expander bytes, a backlight request queues one, and
// each queued byte goes out as an I2C write paced by tick transactions, three
// ticks to a bit slot and sixty to a frame. A request made while bytes are
// still queued is dropped and flagged in its result.
// Every input transaction gives exactly one result transaction on the output
// channel (out_valid, out_stall, out_data) with the line levels after it, the
// busy flag, the sticky acknowledge error flag and the dropped flag.
// An item passes through an input register and a result register before its
// result appears; one item is accepted every cycle while the receiver does not
// stall, with the frame sequencer combinational between those two registers.
// If the receiver stalls, the result register holds, the input register fills
// behind it and in_stall rises the same cycle that the stall blocks progress.
// Registers on the cfg_ port are written with cfg_we; the user must write them
// only while idle, as the block itself does not enforce it. Reset clears the
// pin shadow, the queue count, the frame position and the flags, releases both
// lines high and restores the register defaults.
module lcd_nibble_writer_over_i2c_expander
  import lcdi2c_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [7:0] dev_addr_r;
  pins_t      pins_r;

  // Input register and result register.
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t result;

  // Block state.
  logic [7:0]                  shadow_r, shadow_nxt;
  logic [QUEUE_DEPTH-1:0][7:0] queue_r, queue_nxt;
  logic [QCNT_W-1:0]           count_r, count_nxt;
  bus_state_t                  bus_r, bus_nxt;
  logic                        nack_r, nack_nxt;

  logic      s1_adv, in_accept, busy, is_tick, dropped;
  bus_step_t step;
  req_t      req;

  // The item in the input register moves on whenever the result register is
  // free or is being emptied in the same cycle.
  assign s1_adv    = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = s1_valid_r & ~s1_adv;
  assign in_accept = in_valid & ~in_stall;

  assign busy    = (count_r != '0);
  assign is_tick = (s1_item_r.operation == OP_TICK);

  lcdi2c_bus_seq u_bus_seq (
    .cur       (bus_r),
    .dev_addr  (dev_addr_r),
    .head_byte (queue_r[0]),
    .sda_in    (s1_item_r.sda_in),
    .step      (step)
  );

  lcdi2c_req_build u_req_build (
    .operation (s1_item_r.operation),
    .value     (s1_item_r.value),
    .shadow    (shadow_r),
    .pins      (pins_r),
    .req       (req)
  );

  always_comb begin
    shadow_nxt = shadow_r;
    queue_nxt  = queue_r;
    count_nxt  = count_r;
    bus_nxt    = bus_r;
    nack_nxt   = nack_r;
    dropped    = 1'b0;

    if (s1_adv) begin
      if (is_tick) begin
        // Ticks only move the bus while there is something to send.
        if (busy) begin
          bus_nxt  = step.nxt;
          nack_nxt = nack_r | step.nack_set;
          if (step.frame_end) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              queue_nxt[i] = queue_r[i+1];
            end
            count_nxt = count_r - QCNT_W'(1);
          end
        end
      end else if (busy) begin
        dropped = 1'b1;
      end else begin
        nack_nxt    = 1'b0;
        bus_nxt.slot = SLOT_START;
        bus_nxt.sub  = SUB_SETUP;
        shadow_nxt  = req.shadow;
        count_nxt   = req.count;
        for (int i = 0; i < CMD_BYTES; i++) begin
          queue_nxt[i] = req.bytes[i];
        end
      end
    end

    result.scl_level       = bus_nxt.scl;
    result.sda_level       = bus_nxt.sda;
    result.busy_res        = (count_nxt != '0);
    result.nack_seen       = nack_nxt;
    result.request_dropped = dropped;

    out_valid_nxt = s1_adv | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= 8'd78;
      pins_r      <= '{rs: 3'd0, rw: 3'd1, en: 3'd2, light: 3'd3, nibble: 3'd4};
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      shadow_r    <= '0;
      count_r     <= '0;
      bus_r       <= '{scl: 1'b1, sda: 1'b1, shift: 8'd0, slot: SLOT_START, sub: SUB_SETUP};
      nack_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ADDR:   dev_addr_r    <= cfg_data;
          CFG_RS:     pins_r.rs     <= cfg_data[2:0];
          CFG_RW:     pins_r.rw     <= cfg_data[2:0];
          CFG_EN:     pins_r.en     <= cfg_data[2:0];
          CFG_LIGHT:  pins_r.light  <= cfg_data[2:0];
          CFG_NIBBLE: pins_r.nibble <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
      shadow_r    <= shadow_nxt;
      count_r     <= count_nxt;
      bus_r       <= bus_nxt;
      nack_r      <= nack_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_item_r <= result;
    end
    queue_r <= queue_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // The queue never holds more bytes than it has room for.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // A dropped request is only ever reported while bytes are still queued.
  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.request_dropped |-> out_item_r.busy_res)
    else $error("request dropped while idle");

  // The frame position stays inside the sixty-tick frame.
  a_frame_pos: assert property (@(posedge clk) disable iff (!rst_n)
    bus_r.sub != 2'd3 && bus_r.slot <= SLOT_STOP)
    else $error("frame position out of range");

  // An idle block leaves the bus at the start of a frame with both lines released.
  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> bus_r.scl && bus_r.sda && bus_r.slot == SLOT_START)
    else $error("bus not released while idle");

endmodule

>>> verif/lcd_nibble_writer_over_i2c_expander_tb.sv
module lcd_nibble_writer_over_i2c_expander_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdi2c_pkg::*;

  // One I2C write frame is twenty bit slots of three ticks each.
  localparam int FRAME_TICKS = 3 * (int'(SLOT_STOP) + 1);

  // The result of an item is registered through the input register and then the
  // result register, so the quiet cycles below after the last result are enough
  // before a register write or the end of the run.
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 60;
  localparam int NUM_SETTINGS   = 4;
  localparam int CMD_PHASES     = 2;

  // Tracks the expander pin shadow, the byte queue and the bus frame, and
  // holds the result expected for every transaction that has been accepted.
  class lcd_frame_tracker;
    bit [7:0]    dev_addr;
    bit [2:0]    rs_pos;
    bit [2:0]    rw_pos;
    bit [2:0]    en_pos;
    bit [2:0]    light_pos;
    bit [2:0]    nib_pos;
    bit [7:0]    pins;
    bit [7:0]    frame_bytes [QUEUE_DEPTH];
    int unsigned queued;
    int unsigned phase;
    bit [7:0]    shifter;
    bit          nack;
    bit          scl;
    bit          sda;
    out_item_t   levels_due [$];
    int unsigned faults;
    int unsigned results_checked;
    int unsigned requests_dropped;
    int unsigned nack_samples;
    int unsigned frames_sent;
    int unsigned items_taken;

    function new();
      dev_addr  = 8'd78;
      rs_pos    = 3'd0;
      rw_pos    = 3'd1;
      en_pos    = 3'd2;
      light_pos = 3'd3;
      nib_pos   = 3'd4;
      pins      = '0;
      queued    = 0;
      phase     = 0;
      shifter   = '0;
      nack      = 1'b0;
      scl       = 1'b1;
      sda       = 1'b1;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
    endfunction

    function void set_reg(cfg_idx_t idx, bit [7:0] v);
      case (idx)
        CFG_ADDR:   dev_addr  = v;
        CFG_RS:     rs_pos    = v[2:0];
        CFG_RW:     rw_pos    = v[2:0];
        CFG_EN:     en_pos    = v[2:0];
        CFG_LIGHT:  light_pos = v[2:0];
        CFG_NIBBLE: nib_pos   = v[2:0];
        default: ;
      endcase
    endfunction

    // A position past bit 7 leaves the byte untouched.
    function bit [7:0] with_pin(bit [7:0] v, int unsigned pos, bit b);
      if (pos <= 7) v[pos] = b;
      return v;
    endfunction

    function void push_pins();
      if (queued < QUEUE_DEPTH) begin
        frame_bytes[queued] = pins;
        queued++;
      end
    endfunction

    function void load_nibble(bit [3:0] nib);
      for (int k = 3; k >= 0; k--) begin
        pins = with_pin(pins, int'(nib_pos) + k, nib[k]);
      end
      pins = with_pin(pins, en_pos, 1'b1);
      push_pins();
      pins = with_pin(pins, en_pos, 1'b0);
      push_pins();
    endfunction

    function void step_bus(bit sda_in);
      int unsigned slot;
      int unsigned sub;
      slot = phase / 3;
      sub  = phase % 3;
      if (slot == SLOT_START) begin
        if (sub == SUB_SETUP) begin
          scl = 1'b1;
          sda = 1'b1;
          shifter = dev_addr;
        end else if (sub == SUB_HIGH) begin
          sda = 1'b0;
        end else begin
          scl = 1'b0;
        end
      end else if (slot == SLOT_ACK_ADDR || slot == SLOT_ACK_DATA) begin
        if (sub == SUB_SETUP) begin
          sda = 1'b1;
        end else if (sub == SUB_HIGH) begin
          scl = 1'b1;
          if (sda_in) begin
            nack = 1'b1;
            nack_samples++;
          end
        end else begin
          scl = 1'b0;
        end
      end else if (slot == SLOT_STOP) begin
        if (sub == SUB_SETUP) begin
          sda = 1'b0;
        end else if (sub == SUB_HIGH) begin
          scl = 1'b1;
        end else begin
          sda = 1'b1;
        end
      end else begin
        if (slot == SLOT_DATA_FIRST && sub == SUB_SETUP) shifter = frame_bytes[0];
        if (sub == SUB_SETUP) begin
          sda = shifter[7];
        end else if (sub == SUB_HIGH) begin
          scl = 1'b1;
        end else begin
          scl = 1'b0;
          shifter = shifter << 1;
        end
      end
      phase++;
      if (phase >= FRAME_TICKS) begin
        phase = 0;
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) frame_bytes[i] = frame_bytes[i + 1];
        queued--;
        frames_sent++;
      end
    endfunction

    // Notes an accepted input transaction and queues its expected result.
    function void take_request(in_item_t it);
      out_item_t e;
      bit        dropped;
      op_t       op;
      op      = op_t'(it.operation);
      dropped = 1'b0;
      items_taken++;
      if (op == OP_TICK) begin
        if (queued > 0) begin
          step_bus(it.sda_in);
        end
      end else if (queued > 0) begin
        dropped = 1'b1;
        requests_dropped++;
      end else begin
        nack  = 1'b0;
        phase = 0;
        if (op == OP_LIGHT) begin
          pins = with_pin(pins, light_pos, it.value != 8'd0);
          push_pins();
        end else begin
          pins = with_pin(pins, rs_pos, op == OP_DATA);
          push_pins();
          pins = with_pin(pins, rw_pos, 1'b0);
          push_pins();
          load_nibble(it.value[7:4]);
          load_nibble(it.value[3:0]);
        end
      end
      e.scl_level       = scl;
      e.sda_level       = sda;
      e.busy_res        = queued > 0;
      e.nack_seen       = nack;
      e.request_dropped = dropped;
      levels_due.push_back(e);
    endfunction

    task report(string what);
      faults++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task compare_field(string name, logic got, logic want);
      if (got !== want) begin
        report($sformatf("result %0d field %s is %b, expected %b",
                         results_checked, name, got, want));
      end
    endtask

    // Checks one accepted result transaction against the oldest expectation.
    task match_levels(out_item_t got);
      out_item_t want;
      if (levels_due.size() == 0) begin
        report($sformatf("result %b arrived with nothing outstanding", got));
        return;
      end
      want = levels_due.pop_front();
      results_checked++;
      compare_field("scl_level", got.scl_level, want.scl_level);
      compare_field("sda_level", got.sda_level, want.sda_level);
      compare_field("busy_res", got.busy_res, want.busy_res);
      compare_field("nack_seen", got.nack_seen, want.nack_seen);
      compare_field("request_dropped", got.request_dropped, want.request_dropped);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lcd_frame_tracker tracker;

  // When calm is set neither side idles, which gives stretches of
  // back-to-back transactions on both channels.
  bit          calm;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned settings_used;

  lcd_nibble_writer_over_i2c_expander dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // The receiver holds off for a freshly drawn number of cycles after every
  // result it takes. The stall only changes on the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Results are sampled on the rising edge, before the design's registers
  // move. The watchdog counts cycles in which neither channel moves a
  // transaction; a hang in either direction ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        tracker.match_levels(out_data);
        stall_left = calm ? 0 : $urandom_range(0, 10);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a transaction, %0d results outstanding",
                 quiet_cycles, tracker.levels_due.size());
        $display("lcd_nibble_writer_over_i2c_expander verification failed");
        $finish;
      end
    end
  end

  function automatic in_item_t mk_item(op_t op, logic [7:0] v, logic s);
    in_item_t it;
    it.operation = op;
    it.value     = v;
    it.sda_in    = s;
    return it;
  endfunction

  // Presents one transaction after a random gap and waits until the design
  // takes it. Valid stays high between back-to-back items; only the payload
  // changes on the falling edge after acceptance.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    tracker.take_request(it);
  endtask

  // A tick with a random, ignored value byte. The acknowledge line is read
  // high with the given percentage, which sets the sticky error flag.
  task automatic send_tick(int unsigned pct);
    send_item(mk_item(OP_TICK, 8'($urandom()), $urandom_range(0, 99) < pct));
  endtask

  // Lowers valid and holds the sender back until every result is in.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.levels_due.size() > 0) @(negedge clk);
  endtask

  // Ticks the bus until the byte queue is empty. With noise on, requests
  // are thrown in while busy and must come back flagged as dropped; now and
  // then the sender stops in the middle of a frame until the results catch up.
  task automatic run_bus(int unsigned pct, bit noisy);
    while (tracker.queued > 0) begin
      if (noisy && $urandom_range(0, 24) == 0) begin
        send_item(mk_item(op_t'($urandom_range(1, 3)), 8'($urandom()),
                          1'($urandom_range(0, 1))));
      end else if ($urandom_range(0, 299) == 0) begin
        wait_for_results();
      end else begin
        send_tick(pct);
      end
    end
  endtask

  // Called on a falling edge with the design idle.
  task automatic write_reg(cfg_idx_t idx, logic [7:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    tracker.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Registers are only rewritten once the queue has drained, every result
  // has been seen and the pipeline has had a few cycles to settle.
  task automatic load_setting(logic [7:0] addr, logic [2:0] rs, logic [2:0] rw,
                              logic [2:0] en, logic [2:0] light, logic [2:0] nib);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(CFG_ADDR, addr);
    write_reg(CFG_RS, {5'd0, rs});
    write_reg(CFG_RW, {5'd0, rw});
    write_reg(CFG_EN, {5'd0, en});
    write_reg(CFG_LIGHT, {5'd0, light});
    write_reg(CFG_NIBBLE, {5'd0, nib});
    settings_used++;
  endtask

  initial begin
    int unsigned start_items;
    int unsigned pick;
    bit          first;
    logic [7:0]  v;

    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    calm          = 1'b0;
    stall_left    = 0;
    quiet_cycles  = 0;
    settings_used = 0;
    tracker       = new();

    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed transactions with the register defaults. A tick while idle
    // must leave the released lines alone.
    send_item(mk_item(OP_TICK, 8'hFF, 1'b1));
    // Backlight on with the smallest and the top bit, then off; the frames
    // see every acknowledge low, then every one high, then a mixture.
    send_item(mk_item(OP_LIGHT, 8'h01, 1'b0));
    run_bus(0, 1'b0);
    send_item(mk_item(OP_LIGHT, 8'h80, 1'b0));
    send_tick(100);
    // Every kind of request while bytes are queued is dropped.
    send_item(mk_item(OP_CMD, 8'h12, 1'b0));
    send_item(mk_item(OP_DATA, 8'h34, 1'b1));
    send_item(mk_item(OP_LIGHT, 8'hFF, 1'b0));
    // The sender stops in the middle of a frame until all results are in.
    wait_for_results();
    run_bus(100, 1'b0);
    // A fresh request must clear the sticky acknowledge error.
    send_item(mk_item(OP_LIGHT, 8'h00, 1'b1));
    run_bus(50, 1'b0);

    // Random phases, one per register setting. The first two put every pin
    // on one bit and on bit 7 with the nibble running off the top of the
    // byte; the address takes both extremes. A command or data byte costs
    // six whole frames of ticks, so the first of those phases opens with a command
    // and the second with a data byte; the later ones keep to backlight requests.
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      case (p)
        0: load_setting(8'h00, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0);
        1: load_setting(8'hFF, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7);
        default: load_setting(8'($urandom()), 3'($urandom()), 3'($urandom()),
                              3'($urandom()), 3'($urandom()), 3'($urandom()));
      endcase
      calm        = (p % 3 == 1);
      start_items = tracker.items_taken;
      first       = 1'b1;
      while (first || tracker.items_taken - start_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 19);
        if (first && p < CMD_PHASES) begin
          send_item(mk_item(op_t'(p + 1), 8'($urandom()), 1'($urandom_range(0, 1))));
        end else if (pick < 18) begin
          v = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom());
          send_item(mk_item(OP_LIGHT, v, 1'($urandom_range(0, 1))));
        end else begin
          send_tick(50);
        end
        first = 1'b0;
        run_bus(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 30), 1'b1);
      end
    end
    calm = 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.levels_due.size() > 0) begin
      tracker.report($sformatf("%0d results never arrived", tracker.levels_due.size()));
    end

    $display("Run covered %0d register settings, %0d expander frames and %0d results.",
             settings_used, tracker.frames_sent, tracker.results_checked);
    $display("Requests dropped while busy: %0d; acknowledge slots read high: %0d.",
             tracker.requests_dropped, tracker.nack_samples);
    if (tracker.faults == 0) begin
      $display("lcd_nibble_writer_over_i2c_expander verification clean");
    end else begin
      $display("lcd_nibble_writer_over_i2c_expander verification failed");
    end
    $finish;
  end

endmodule
